FILE: hw/rtl/mt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and word functions for the MT19937 generator.
// No dependencies; used by the control path and the table memory.
package mt_pkg;

  localparam int ADDR_W = 10;
  localparam int WORD_W = 32;

  localparam logic [ADDR_W-1:0] TBL_N = 10'd624;
  localparam logic [ADDR_W-1:0] TBL_M = 10'd397;

  localparam logic [WORD_W-1:0] TWIST_XOR      = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HI_BIT         = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LO_BITS        = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B       = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C       = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT      = 32'd69069;
  localparam logic [WORD_W-1:0] RESET_FALLBACK = 32'd4357;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  // Write port plus two read ports of the state table
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re_a;
    logic [ADDR_W-1:0] raddr_a;
    logic              re_b;
    logic [ADDR_W-1:0] raddr_b;
  } mt_mem_req_t;

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] upper,
                                                   input logic [WORD_W-1:0] lower,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    y = (upper & HI_BIT) | (lower & LO_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: hw/rtl/mt_req_if.sv
`timescale 1ns / 1ps
// Request channel of the generator: operation code and seed.
// Standalone; valid/ready transfer.
interface mt_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed_value;

  modport source(output valid, output operation, output seed_value, input ready);
  modport sink(input valid, input operation, input seed_value, output ready);
endinterface

FILE: hw/rtl/mt_word_if.sv
`timescale 1ns / 1ps
// Result channel of the generator: one tempered random word.
// Standalone; valid/ready transfer.
interface mt_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source(output valid, output random_word, input ready);
  modport sink(input valid, input random_word, output ready);
endinterface

FILE: hw/rtl/mt_table.sv
`timescale 1ns / 1ps
// State table: 624 words, one write port, two read ports, registered reads.
// Depends on mt_pkg for sizes and the request struct.
module mt_table (
  input  logic                      clk,
  input  mt_pkg::mt_mem_req_t       req,
  output logic [mt_pkg::WORD_W-1:0] rdata_a,
  output logic [mt_pkg::WORD_W-1:0] rdata_b
);
  import mt_pkg::*;

  logic [WORD_W-1:0] mem [TBL_N];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re_a) begin
      rdata_a <= mem[req.raddr_a];
    end
    if (req.re_b) begin
      rdata_b <= mem[req.raddr_b];
    end
  end

endmodule

FILE: hw/rtl/mt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer and datapath: seeding sweep, on-the-fly twist, tempering, output register.
// Depends on mt_pkg, mt_req_if and mt_word_if; drives the mt_table ports.
module mt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mt_pkg::WORD_W-1:0] cfg_wdata,
  mt_req_if.sink                    req,
  mt_word_if.source                 rsp,
  output mt_pkg::mt_mem_req_t       mem_req,
  input  logic [mt_pkg::WORD_W-1:0] rdata_a,
  input  logic [mt_pkg::WORD_W-1:0] rdata_b
);
  import mt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_PRIME,
    S_ISSUE,
    S_TWIST
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] fallback;
  logic [WORD_W-1:0] fill_word;
  logic [ADDR_W-1:0] fill_addr;
  logic              draw_pend;
  logic              seeded;
  logic [ADDR_W-1:0] idx;
  logic [WORD_W-1:0] cur_word;
  logic              cache_valid;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;

  logic [ADDR_W-1:0] idx_wrap;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W-1:0] far_addr;
  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] fill_word_next;
  logic              out_free;

  assign idx_wrap       = (idx >= TBL_N) ? '0 : idx;
  assign nxt_addr       = (idx == TBL_N - 10'd1) ? '0 : idx + 10'd1;
  assign far_addr       = (idx >= TBL_N - TBL_M) ? idx - (TBL_N - TBL_M) : idx + TBL_M;
  assign twisted        = twist_word(cur_word, rdata_a, rdata_b);
  assign fill_word_next = fill_word * SEED_MULT;
  assign out_free       = !out_valid || rsp.ready;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  always_comb begin
    mem_req = '0;
    unique case (state)
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr;
        mem_req.wdata = fill_word;
      end
      S_PRIME: begin
        mem_req.re_a    = 1'b1;
        mem_req.raddr_a = idx;
      end
      S_ISSUE: begin
        mem_req.re_a    = 1'b1;
        mem_req.raddr_a = nxt_addr;
        mem_req.re_b    = 1'b1;
        mem_req.raddr_b = far_addr;
      end
      S_TWIST: begin
        mem_req.we    = out_free;
        mem_req.waddr = idx;
        mem_req.wdata = twisted;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fallback    <= RESET_FALLBACK;
      draw_pend   <= 1'b0;
      seeded      <= 1'b0;
      idx         <= TBL_N;
      cache_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        fallback <= cfg_wdata;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.operation == OP_RESEED) begin
              fill_word   <= (req.seed_value != '0) ? req.seed_value : fallback;
              fill_addr   <= '0;
              draw_pend   <= 1'b0;
              cache_valid <= 1'b0;
              state       <= S_FILL;
            end else if (!seeded) begin
              fill_word   <= fallback;
              fill_addr   <= '0;
              draw_pend   <= 1'b1;
              cache_valid <= 1'b0;
              state       <= S_FILL;
            end else begin
              idx   <= idx_wrap;
              state <= cache_valid ? S_ISSUE : S_PRIME;
            end
          end
        end
        S_FILL: begin
          fill_word <= fill_word_next;
          fill_addr <= fill_addr + 10'd1;
          if (fill_addr == TBL_N - 10'd1) begin
            seeded <= 1'b1;
            if (draw_pend) begin
              idx   <= '0;
              state <= S_PRIME;
            end else begin
              idx   <= TBL_N;
              state <= S_IDLE;
            end
          end
        end
        S_PRIME: begin
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          // first draw after seeding takes the current word from the prime read
          if (!cache_valid) begin
            cur_word    <= rdata_a;
            cache_valid <= 1'b1;
          end
          state <= S_TWIST;
        end
        S_TWIST: begin
          // hold until the output register is free
          if (out_free) begin
            out_word  <= temper(twisted);
            out_valid <= 1'b1;
            cur_word  <= rdata_a;
            idx       <= idx + 10'd1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// MT19937 generator top level: sequencer plus 624-word state table.
// Draw: S_ISSUE, S_TWIST (waits for a free output register); S_PRIME first after a reseed;
// each draw twists one table word in place, set by two table reads and a write-back.
// Reseed: S_FILL writes one table word per cycle; a draw before any seeding fills first.
// One item in flight; a finished word waits in the output register while the next is taken.
// Reset (synchronous, active high) clears control state; table contents stay undefined.
module mersenne_twister_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mt_pkg::WORD_W-1:0] cfg_wdata,
  mt_req_if.sink                    req,
  mt_word_if.source                 rsp
);
  import mt_pkg::*;

  mt_mem_req_t       mem_req;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  mt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

  mt_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

FILE: hw/rtl/mt_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the generator, attached to the top level by bind.
// Depends on mt_pkg, mersenne_twister_generator and its channel interfaces.
module mt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_operation,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_word
);
  import mt_pkg::*;

  // output register is empty after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled result holds its word
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("stalled result changed");

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a reseed taken while no result is waiting does not make the result valid right after it
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation == OP_RESEED && !rsp_valid |=> !rsp_valid)
    else $error("reseed produced a result");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_operation (req.operation),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_word      (rsp.random_word)
);
